FILE: rtl/core/qsed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsed_pkg
// Types and constants shared by the quoted string escape decoder.
// ----------------------------------------------------------------------------
package qsed_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_STR   = 3'd1,
      MODE_ESC   = 3'd2,
      MODE_CODE  = 3'd3,
      MODE_CONT  = 3'd4,
      MODE_WS    = 3'd5,
      MODE_LINE  = 3'd6,
      MODE_BLOCK = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ERR_EOF  = 2'd0,
      ERR_NL   = 2'd1,
      ERR_CODE = 2'd2,
      ERR_ESC  = 2'd3
   } err_type;

   typedef struct packed {
      mode_type   mode;
      logic       high_mask_on;
      logic [7:0] code_accum;
      logic       colon_seen;
      logic       last_was_star;
   } state_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       is_last;
      logic       byte_taken;
      logic       is_error;
      err_type    error_kind;
   } result_type;

   localparam state_type STATE_RESET = '{
      mode: MODE_IDLE, high_mask_on: 1'b0, code_accum: 8'd0,
      colon_seen: 1'b0, last_was_star: 1'b0
   };

   localparam int DATA_IN_W  = 16;
   localparam int DATA_OUT_W = 8;
   localparam int USER_OUT_W = 4;

   localparam logic [7:0] CH_EOF    = 8'd0;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_QUOTE  = 8'd34;
   localparam logic [7:0] CH_LPAR   = 8'd40;
   localparam logic [7:0] CH_RPAR   = 8'd41;
   localparam logic [7:0] CH_STAR   = 8'd42;
   localparam logic [7:0] CH_MINUS  = 8'd45;
   localparam logic [7:0] CH_DOT    = 8'd46;
   localparam logic [7:0] CH_SLASH  = 8'd47;
   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_NINE   = 8'd57;
   localparam logic [7:0] CH_COLON  = 8'd58;
   localparam logic [7:0] CH_LT     = 8'd60;
   localparam logic [7:0] CH_EQ     = 8'd61;
   localparam logic [7:0] CH_GT     = 8'd62;
   localparam logic [7:0] CH_LBRK   = 8'd91;
   localparam logic [7:0] CH_BSLASH = 8'd92;
   localparam logic [7:0] CH_RBRK   = 8'd93;
   localparam logic [7:0] CH_B      = 8'd98;
   localparam logic [7:0] CH_N      = 8'd110;
   localparam logic [7:0] CH_T      = 8'd116;
   localparam logic [7:0] CH_LBRACE = 8'd123;
   localparam logic [7:0] CH_RBRACE = 8'd125;
   localparam logic [7:0] CH_HIGH   = 8'd128;

   localparam logic [7:0] GC_LBRK   = 8'd16;
   localparam logic [7:0] GC_RBRK   = 8'd17;
   localparam logic [7:0] GC_DIGIT0 = 8'd18;
   localparam logic [7:0] GC_DOT    = 8'd28;
   localparam logic [7:0] GC_LT     = 8'd29;
   localparam logic [7:0] GC_MINUS  = 8'd30;
   localparam logic [7:0] GC_GT     = 8'd31;
   localparam logic [7:0] GC_LPAR   = 8'd128;
   localparam logic [7:0] GC_EQ     = 8'd129;
   localparam logic [7:0] GC_RPAR   = 8'd130;
   localparam logic [7:0] CODE_MAX  = 8'd255;

endpackage

FILE: rtl/core/quoted_string_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_escape_decoder
// Decodes one quoted string literal from a byte stream into characters.
// ----------------------------------------------------------------------------
// The block takes one source byte per item, together with the byte after it,
// starting with the opening quote, and returns zero or one result item per
// input item. It accepts a new item in every cycle while the output register
// is empty or its item is being taken; the result of an item appears on the
// result channel in the cycle after the item is accepted. While a result waits
// in the output register and the result channel stalls, input items are held
// off. The decoder state register, updated once per accepted item, sets this
// rate. A result with tlast high carries the zero terminator and marks its
// source byte as not consumed; error results return the block to idle.
module quoted_string_escape_decoder
   import qsed_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // src_byte [7:0], peek_byte [15:8]
   input  logic [DATA_IN_W-1:0]  req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_char [7:0]
   output logic [DATA_OUT_W-1:0] rsp_tdata,
   // is_last
   output logic                  rsp_tlast,
   // byte_taken [0], is_error [1], error_kind [3:2]
   output logic [USER_OUT_W-1:0] rsp_tuser
);

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       accept;
   logic       step_valid;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   qsed_step u_step (
      .state_cur (state_ff),
      .src_byte  (req_tdata[7:0]),
      .peek_byte (req_tdata[15:8]),
      .state_nxt (state_in),
      .res_valid (step_valid),
      .res       (rsp_in)
   );

   assign rsp_valid_in = accept ? step_valid : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.out_char;
   assign rsp_tlast  = rsp_ff.is_last;
   assign rsp_tuser  = {rsp_ff.error_kind, rsp_ff.is_error, rsp_ff.byte_taken};

   a_err_idle: assert property (@(posedge clock) disable iff (reset)
      accept && step_valid && rsp_in.is_error |=> state_ff.mode == MODE_IDLE)
      else $error("error result did not return the decoder to idle");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      accept && step_valid && rsp_in.is_last |=> state_ff.mode == MODE_IDLE)
      else $error("terminator did not return the decoder to idle");

   a_err_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.is_last && rsp_ff.is_error))
      else $error("result is both terminator and error");

   a_untaken_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.byte_taken |-> rsp_ff.is_last && rsp_ff.out_char == 8'd0)
      else $error("unconsumed byte on a result that is not the terminator");

   a_kind_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.is_error |-> rsp_ff.error_kind == ERR_EOF)
      else $error("error kind set without an error");

endmodule

FILE: rtl/core/qsed_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsed_step
// Next-state and result logic for one source byte of the string decoder.
// ----------------------------------------------------------------------------
module qsed_step
   import qsed_pkg::*;
(
   input  state_type  state_cur,
   input  logic [7:0] src_byte,
   input  logic [7:0] peek_byte,
   output state_type  state_nxt,
   output logic       res_valid,
   output result_type res
);

   localparam result_type RES_NONE = '{
      out_char: 8'd0, is_last: 1'b0, byte_taken: 1'b1, is_error: 1'b0,
      error_kind: ERR_EOF
   };
   localparam result_type RES_FINISH = '{
      out_char: 8'd0, is_last: 1'b1, byte_taken: 1'b0, is_error: 1'b0,
      error_kind: ERR_EOF
   };

   state_type  str_state;
   logic       str_valid;
   result_type str_res;
   logic [7:0] mask;
   logic       is_digit;
   logic [7:0] digit;
   logic [11:0] code_sum;

   assign mask     = state_cur.high_mask_on ? CH_HIGH : 8'd0;
   assign is_digit = (src_byte >= CH_ZERO) && (src_byte <= CH_NINE);
   assign digit    = src_byte - CH_ZERO;
   assign code_sum = {1'b0, state_cur.code_accum, 3'd0}
                   + {3'd0, state_cur.code_accum, 1'b0}
                   + {4'd0, digit};

   function automatic result_type fail_res(input err_type kind);
      result_type r;
      r            = RES_NONE;
      r.is_error   = 1'b1;
      r.error_kind = kind;
      return r;
   endfunction

   function automatic result_type char_res(input logic [7:0] ch);
      result_type r;
      r          = RES_NONE;
      r.out_char = ch;
      return r;
   endfunction

   // Handling of a byte inside the string body, shared by the string and
   // continuation modes.
   always_comb begin
      str_state      = state_cur;
      str_state.mode = MODE_STR;
      str_valid      = 1'b0;
      str_res        = RES_NONE;
      if (src_byte == CH_EOF) begin
         str_state = STATE_RESET;
         str_valid = 1'b1;
         str_res   = fail_res(ERR_EOF);
      end else if (src_byte == CH_LF) begin
         str_state = STATE_RESET;
         str_valid = 1'b1;
         str_res   = fail_res(ERR_NL);
      end else if (src_byte == CH_CR) begin
         str_valid = 1'b0;
      end else if (src_byte == CH_BSLASH) begin
         str_state.mode = MODE_ESC;
      end else if (src_byte == CH_QUOTE) begin
         str_state.high_mask_on = 1'b0;
         str_state.colon_seen   = 1'b0;
         str_state.mode         = MODE_WS;
      end else begin
         str_valid = 1'b1;
         str_res   = char_res(src_byte | mask);
      end
   end

   always_comb begin
      state_nxt = state_cur;
      res_valid = 1'b0;
      res       = RES_NONE;
      case (state_cur.mode)
         MODE_IDLE: begin
            state_nxt      = STATE_RESET;
            state_nxt.mode = MODE_STR;
         end
         MODE_STR: begin
            state_nxt = str_state;
            res_valid = str_valid;
            res       = str_res;
         end
         MODE_ESC: begin
            state_nxt.mode = MODE_STR;
            res_valid      = 1'b1;
            if (src_byte == CH_EOF) begin
               state_nxt = STATE_RESET;
               res       = fail_res(ERR_EOF);
            end else if (is_digit) begin
               res = char_res(src_byte - (CH_ZERO - GC_DIGIT0));
            end else begin
               case (src_byte)
                  CH_N:      res = char_res(CH_LF);
                  CH_T:      res = char_res(CH_TAB);
                  CH_QUOTE:  res = char_res(CH_QUOTE | mask);
                  CH_BSLASH: res = char_res(CH_BSLASH | mask);
                  CH_DOT:    res = char_res(GC_DOT | mask);
                  CH_LBRK:   res = char_res(GC_LBRK);
                  CH_RBRK:   res = char_res(GC_RBRK);
                  CH_LT:     res = char_res(GC_LT);
                  CH_MINUS:  res = char_res(GC_MINUS);
                  CH_GT:     res = char_res(GC_GT);
                  CH_LPAR:   res = char_res(GC_LPAR);
                  CH_EQ:     res = char_res(GC_EQ);
                  CH_RPAR:   res = char_res(GC_RPAR);
                  CH_B: begin
                     state_nxt.high_mask_on = ~state_cur.high_mask_on;
                     res_valid              = 1'b0;
                  end
                  CH_LF, CH_CR: begin
                     state_nxt.mode = MODE_CONT;
                     res_valid      = 1'b0;
                  end
                  CH_LBRACE: begin
                     state_nxt.code_accum = 8'd0;
                     state_nxt.mode       = MODE_CODE;
                     res_valid            = 1'b0;
                  end
                  default: begin
                     state_nxt = STATE_RESET;
                     res       = fail_res(ERR_ESC);
                  end
               endcase
            end
         end
         MODE_CODE: begin
            if (src_byte == CH_RBRACE) begin
               state_nxt.mode = MODE_STR;
               res_valid      = 1'b1;
               res            = char_res(state_cur.code_accum);
            end else if (!is_digit || (code_sum > {4'd0, CODE_MAX})) begin
               state_nxt = STATE_RESET;
               res_valid = 1'b1;
               res       = fail_res(ERR_CODE);
            end else begin
               state_nxt.code_accum = code_sum[7:0];
            end
         end
         MODE_CONT: begin
            if ((src_byte != CH_LF) && (src_byte != CH_CR)) begin
               state_nxt = str_state;
               res_valid = str_valid;
               res       = str_res;
            end
         end
         MODE_WS: begin
            if (src_byte == CH_EOF) begin
               state_nxt = STATE_RESET;
               res_valid = 1'b1;
               res       = RES_FINISH;
            end else if ((src_byte <= CH_SPACE) || (src_byte >= CH_HIGH)) begin
               res_valid = 1'b0;
            end else if ((src_byte == CH_SLASH) && (peek_byte == CH_SLASH)) begin
               state_nxt.mode = MODE_LINE;
            end else if ((src_byte == CH_SLASH) && (peek_byte == CH_STAR)) begin
               state_nxt.mode          = MODE_BLOCK;
               state_nxt.last_was_star = 1'b0;
            end else if ((src_byte == CH_COLON) && !state_cur.colon_seen) begin
               state_nxt.colon_seen = 1'b1;
               res_valid            = 1'b1;
               res                  = char_res(8'd0);
            end else if (src_byte == CH_QUOTE) begin
               state_nxt.colon_seen = 1'b0;
               state_nxt.mode       = MODE_STR;
            end else begin
               state_nxt = STATE_RESET;
               res_valid = 1'b1;
               res       = RES_FINISH;
            end
         end
         MODE_LINE: begin
            if (src_byte == CH_EOF) begin
               state_nxt = STATE_RESET;
               res_valid = 1'b1;
               res       = RES_FINISH;
            end else if (src_byte == CH_LF) begin
               state_nxt.mode = MODE_WS;
            end
         end
         MODE_BLOCK: begin
            if (src_byte == CH_EOF) begin
               state_nxt = STATE_RESET;
               res_valid = 1'b1;
               res       = RES_FINISH;
            end else if (state_cur.last_was_star && (src_byte == CH_SLASH)) begin
               state_nxt.last_was_star = 1'b0;
               state_nxt.mode          = MODE_WS;
            end else begin
               state_nxt.last_was_star = (src_byte == CH_STAR);
            end
         end
         default: begin
            state_nxt = STATE_RESET;
         end
      endcase
   end

endmodule

FILE: tb/quoted_string_escape_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_escape_decoder_tb
// Self-checking testbench for the quoted string escape decoder.
// ----------------------------------------------------------------------------
// Source bytes are generated as whole string literals with escapes, brace
// codes, continuations, comments, colons and terminators, mixed with broken
// literals and noise. A behavioral decoder predicts the character stream for
// every accepted byte, and each result item is compared field by field with
// the oldest predicted character. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module quoted_string_escape_decoder_tb
   import qsed_pkg::*;
();

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PERIODIC
   } ready_style_type;

   localparam int RANDOM_BYTES = 340;
   localparam int NUM_ESCAPES  = 14;
   localparam logic [NUM_ESCAPES*8-1:0] ESCAPE_CHARS = {
      CH_B, CH_RPAR, CH_EQ, CH_LPAR, CH_GT, CH_MINUS, CH_LT,
      CH_RBRK, CH_LBRK, CH_DOT, CH_BSLASH, CH_QUOTE, CH_T, CH_N
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_IN_W-1:0]  req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_OUT_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic [USER_OUT_W-1:0] rsp_tuser;

   logic [7:0]            source_text[$];
   logic [DATA_IN_W-1:0]  pending_items[$];
   result_type            expected_chars[$];
   int                    mismatch_count = 0;
   bit                    req_taken = 1'b0;
   int                    burst_left = 0;
   int                    gap_left = 0;
   int                    stall_left = 0;
   ready_style_type       ready_style = READY_ALWAYS;

   mode_type              dec_mode = MODE_IDLE;
   logic                  dec_mask = 1'b0;
   logic [7:0]            dec_code = 8'd0;
   logic                  dec_colon = 1'b0;
   logic                  dec_star = 1'b0;

   quoted_string_escape_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic clear_decoder();
      dec_mode  = MODE_IDLE;
      dec_mask  = 1'b0;
      dec_code  = 8'd0;
      dec_colon = 1'b0;
      dec_star  = 1'b0;
   endtask

   task automatic emit_char(input logic [7:0] ch, output bit produced, output result_type r);
      produced     = 1'b1;
      r.out_char   = ch;
      r.is_last    = 1'b0;
      r.byte_taken = 1'b1;
      r.is_error   = 1'b0;
      r.error_kind = ERR_EOF;
   endtask

   task automatic abort_string(input err_type kind, output bit produced, output result_type r);
      clear_decoder();
      emit_char(8'd0, produced, r);
      r.is_error   = 1'b1;
      r.error_kind = kind;
   endtask

   task automatic end_string(output bit produced, output result_type r);
      clear_decoder();
      emit_char(8'd0, produced, r);
      r.is_last    = 1'b1;
      r.byte_taken = 1'b0;
   endtask

   task automatic decode_string_char(input logic [7:0] c, output bit produced,
                                     output result_type r);
      produced = 1'b0;
      r = '0;
      dec_mode = MODE_STR;
      if (c == CH_EOF) begin
         abort_string(ERR_EOF, produced, r);
      end else if (c == CH_LF) begin
         abort_string(ERR_NL, produced, r);
      end else if (c == CH_BSLASH) begin
         dec_mode = MODE_ESC;
      end else if (c == CH_QUOTE) begin
         dec_mask  = 1'b0;
         dec_colon = 1'b0;
         dec_mode  = MODE_WS;
      end else if (c != CH_CR) begin
         emit_char(c | (dec_mask ? CH_HIGH : 8'd0), produced, r);
      end
   endtask

   task automatic decode_source_byte(input logic [7:0] c, input logic [7:0] p,
                                     output bit produced, output result_type r);
      logic [7:0] mask_bits;
      int         code_next;
      produced = 1'b0;
      r = '0;
      mask_bits = dec_mask ? CH_HIGH : 8'd0;
      case (dec_mode)
         MODE_IDLE: begin
            clear_decoder();
            dec_mode = MODE_STR;
         end
         MODE_STR: begin
            decode_string_char(c, produced, r);
         end
         MODE_ESC: begin
            dec_mode = MODE_STR;
            if (c >= CH_ZERO && c <= CH_NINE) begin
               emit_char(GC_DIGIT0 + (c - CH_ZERO), produced, r);
            end else begin
               case (c)
                  CH_EOF:       abort_string(ERR_EOF, produced, r);
                  CH_N:         emit_char(CH_LF, produced, r);
                  CH_T:         emit_char(CH_TAB, produced, r);
                  CH_QUOTE:     emit_char(CH_QUOTE | mask_bits, produced, r);
                  CH_BSLASH:    emit_char(CH_BSLASH | mask_bits, produced, r);
                  CH_DOT:       emit_char(GC_DOT | mask_bits, produced, r);
                  CH_LBRK:      emit_char(GC_LBRK, produced, r);
                  CH_RBRK:      emit_char(GC_RBRK, produced, r);
                  CH_LT:        emit_char(GC_LT, produced, r);
                  CH_MINUS:     emit_char(GC_MINUS, produced, r);
                  CH_GT:        emit_char(GC_GT, produced, r);
                  CH_LPAR:      emit_char(GC_LPAR, produced, r);
                  CH_EQ:        emit_char(GC_EQ, produced, r);
                  CH_RPAR:      emit_char(GC_RPAR, produced, r);
                  CH_B:         dec_mask = ~dec_mask;
                  CH_LF, CH_CR: dec_mode = MODE_CONT;
                  CH_LBRACE: begin
                     dec_code = 8'd0;
                     dec_mode = MODE_CODE;
                  end
                  default:      abort_string(ERR_ESC, produced, r);
               endcase
            end
         end
         MODE_CODE: begin
            if (c == CH_RBRACE) begin
               dec_mode = MODE_STR;
               emit_char(dec_code, produced, r);
            end else if (c < CH_ZERO || c > CH_NINE) begin
               abort_string(ERR_CODE, produced, r);
            end else begin
               code_next = int'(dec_code) * 10 + int'(c) - int'(CH_ZERO);
               if (code_next > int'(CODE_MAX)) begin
                  abort_string(ERR_CODE, produced, r);
               end else begin
                  dec_code = code_next[7:0];
               end
            end
         end
         MODE_CONT: begin
            if (c != CH_LF && c != CH_CR) begin
               decode_string_char(c, produced, r);
            end
         end
         MODE_WS: begin
            if (c == CH_EOF) begin
               end_string(produced, r);
            end else if (c <= CH_SPACE || c >= CH_HIGH) begin
               produced = 1'b0;
            end else if (c == CH_SLASH && p == CH_SLASH) begin
               dec_mode = MODE_LINE;
            end else if (c == CH_SLASH && p == CH_STAR) begin
               dec_mode = MODE_BLOCK;
               dec_star = 1'b0;
            end else if (c == CH_COLON && !dec_colon) begin
               dec_colon = 1'b1;
               emit_char(8'd0, produced, r);
            end else if (c == CH_QUOTE) begin
               dec_colon = 1'b0;
               dec_mode  = MODE_STR;
            end else begin
               end_string(produced, r);
            end
         end
         MODE_LINE: begin
            if (c == CH_EOF) begin
               end_string(produced, r);
            end else if (c == CH_LF) begin
               dec_mode = MODE_WS;
            end
         end
         default: begin
            if (c == CH_EOF) begin
               end_string(produced, r);
            end else if (dec_star && c == CH_SLASH) begin
               dec_star = 1'b0;
               dec_mode = MODE_WS;
            end else begin
               dec_star = (c == CH_STAR);
            end
         end
      endcase
   endtask

   task automatic add_string_body(input int parts);
      logic [7:0] ch;
      int         code;
      for (int i = 0; i < parts; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               do ch = 8'($urandom_range(1, 255));
               while (ch == CH_LF || ch == CH_CR || ch == CH_QUOTE || ch == CH_BSLASH);
               source_text.push_back(ch);
            end
            4: source_text.push_back(CH_CR);
            5, 6: begin
               source_text.push_back(CH_BSLASH);
               if ($urandom_range(0, 3) == 0) begin
                  source_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
               end else begin
                  source_text.push_back(ESCAPE_CHARS[8*$urandom_range(0, NUM_ESCAPES-1) +: 8]);
               end
            end
            7: begin
               source_text.push_back(CH_BSLASH);
               source_text.push_back(CH_LBRACE);
               if ($urandom_range(0, 5) != 0) begin
                  code = $urandom_range(0, 255);
                  if ($urandom_range(0, 7) == 0) source_text.push_back(CH_ZERO);
                  if (code >= 100) source_text.push_back(CH_ZERO + 8'(code / 100));
                  if (code >= 10) source_text.push_back(CH_ZERO + 8'((code / 10) % 10));
                  source_text.push_back(CH_ZERO + 8'(code % 10));
               end
               source_text.push_back(CH_RBRACE);
            end
            8: begin
               source_text.push_back(CH_BSLASH);
               repeat ($urandom_range(1, 3)) begin
                  source_text.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
               end
            end
            default: begin
               source_text.push_back(CH_BSLASH);
               source_text.push_back(CH_B);
            end
         endcase
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_tdata  <= pending_items.pop_front();
            req_tvalid <= 1'b1;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_left  = $urandom_range(16, 80);
         ready_style = ready_style_type'($urandom_range(0, 2));
      end
      stall_left = stall_left - 1;
      case (ready_style)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
         default:        rsp_tready <= ((stall_left % 5) < 2);
      endcase
   end

   always @(posedge clock) begin
      bit         produced;
      result_type predicted;
      result_type oldest;
      req_taken = 1'b0;
      if (reset) begin
         clear_decoder();
      end else begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            decode_source_byte(req_tdata[7:0], req_tdata[15:8], produced, predicted);
            if (produced) expected_chars.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, got char %h last %b user %h",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               oldest = expected_chars.pop_front();
               if (rsp_tdata !== oldest.out_char || rsp_tlast !== oldest.is_last ||
                   rsp_tuser[0] !== oldest.byte_taken || rsp_tuser[1] !== oldest.is_error ||
                   rsp_tuser[3:2] !== oldest.error_kind) begin
                  mismatch_count++;
                  $display("%0t: mismatch, expected %h %b %b %b %0d, got %h %b %b %b %0d",
                           $time, oldest.out_char, oldest.is_last, oldest.byte_taken,
                           oldest.is_error, oldest.error_kind, rsp_tdata, rsp_tlast,
                           rsp_tuser[0], rsp_tuser[1], rsp_tuser[3:2]);
               end
            end
         end
      end
   end

   initial begin
      int         directed_len;
      logic [7:0] ch;
      logic [7:0] peek;
      source_text = '{
         8'hFF, 8'h41, CH_CR,
         CH_BSLASH, CH_B, 8'h7F, 8'h01, CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_DOT,
         CH_BSLASH, CH_LBRACE, CH_ZERO + 8'd2, CH_ZERO + 8'd5, CH_ZERO + 8'd5, CH_RBRACE,
         CH_BSLASH, CH_LF, CH_CR, CH_LF,
         CH_QUOTE, CH_HIGH, 8'hFF, CH_SPACE, CH_SLASH, CH_STAR, CH_SLASH,
         CH_COLON, CH_QUOTE, CH_BSLASH, CH_LBRACE, CH_RBRACE, CH_QUOTE, CH_COLON, CH_COLON,
         CH_QUOTE, CH_BSLASH, CH_LBRACE, CH_ZERO + 8'd2, CH_ZERO + 8'd5, CH_ZERO + 8'd6,
         CH_QUOTE, CH_LF, CH_QUOTE, CH_EOF, CH_QUOTE, CH_BSLASH, 8'h71,
         CH_QUOTE, CH_QUOTE, CH_SLASH, CH_STAR, CH_EOF
      };
      directed_len = source_text.size();

      while (source_text.size() < directed_len + RANDOM_BYTES) begin
         if ($urandom_range(0, 99) < 85) begin
            source_text.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : CH_QUOTE);
            add_string_body($urandom_range(0, 8));
            source_text.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 3)) begin
               case ($urandom_range(0, 4))
                  0: begin
                     repeat ($urandom_range(1, 3)) begin
                        source_text.push_back($urandom_range(0, 1) ?
                                              8'($urandom_range(1, 32)) :
                                              8'($urandom_range(128, 255)));
                     end
                  end
                  1: begin
                     source_text.push_back(CH_SLASH);
                     source_text.push_back(CH_SLASH);
                     repeat ($urandom_range(0, 5)) begin
                        do ch = 8'($urandom_range(1, 255));
                        while (ch == CH_LF);
                        source_text.push_back(ch);
                     end
                     source_text.push_back(CH_LF);
                  end
                  2: begin
                     source_text.push_back(CH_SLASH);
                     source_text.push_back(CH_STAR);
                     if ($urandom_range(0, 3) == 0) begin
                        source_text.push_back(CH_SLASH);
                     end else begin
                        repeat ($urandom_range(0, 5)) begin
                           source_text.push_back(8'($urandom_range(1, 255)));
                        end
                        source_text.push_back(CH_STAR);
                        source_text.push_back(CH_SLASH);
                     end
                  end
                  3: source_text.push_back(CH_COLON);
                  default: begin
                     source_text.push_back(CH_QUOTE);
                     add_string_body($urandom_range(0, 4));
                     source_text.push_back(CH_QUOTE);
                  end
               endcase
            end
            if ($urandom_range(0, 7) == 0) begin
               source_text.push_back(CH_EOF);
            end else begin
               do ch = 8'($urandom_range(33, 126));
               while (ch == CH_QUOTE || ch == CH_COLON || ch == CH_SLASH);
               source_text.push_back(ch);
            end
         end else begin
            case ($urandom_range(0, 5))
               0: begin
                  repeat ($urandom_range(1, 6)) source_text.push_back(8'($urandom));
               end
               1, 2: begin
                  source_text.push_back(CH_QUOTE);
                  add_string_body($urandom_range(0, 4));
                  source_text.push_back($urandom_range(0, 1) ? CH_EOF : CH_LF);
               end
               3: begin
                  source_text.push_back(CH_QUOTE);
                  source_text.push_back(CH_BSLASH);
                  source_text.push_back(CH_LBRACE);
                  repeat ($urandom_range(1, 4)) begin
                     source_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                  end
                  source_text.push_back($urandom_range(0, 1) ? CH_RBRACE : 8'($urandom));
               end
               4: begin
                  source_text.push_back(CH_QUOTE);
                  source_text.push_back(CH_BSLASH);
                  source_text.push_back(($urandom_range(0, 3) == 0) ? CH_EOF : 8'($urandom));
               end
               default: begin
                  source_text.push_back(CH_QUOTE);
                  add_string_body($urandom_range(0, 3));
                  source_text.push_back(CH_QUOTE);
                  source_text.push_back(CH_SLASH);
                  source_text.push_back($urandom_range(0, 1) ? CH_STAR : CH_SLASH);
                  repeat ($urandom_range(0, 4)) begin
                     source_text.push_back(8'($urandom_range(1, 255)));
                  end
                  source_text.push_back(CH_EOF);
               end
            endcase
         end
      end

      for (int i = 0; i < source_text.size(); i++) begin
         if (i + 1 < source_text.size() &&
             (i < directed_len || $urandom_range(0, 9) != 0)) begin
            peek = source_text[i+1];
         end else begin
            peek = 8'($urandom);
         end
         pending_items.push_back({peek, source_text[i]});
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_tvalid || expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("quoted_string_escape_decoder verification clean");
      end else begin
         $display("quoted_string_escape_decoder verification failed");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("quoted_string_escape_decoder verification failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/qsed_pkg.sv
rtl/core/qsed_step.sv
rtl/core/quoted_string_escape_decoder.sv
tb/quoted_string_escape_decoder_tb.sv
